@@ rtl/cda_pkg.sv @@
// Calendar date arithmetic package: request/result types, status codes,
// state encoding, calendar constants and the small leap/month helpers.
// No dependencies.
package cda_pkg;

	localparam int MAX_YEAR       = 9999;
	localparam int YEAR_FIELD_MAX = 16383;
	localparam int YEAR_LIMIT_INT = (MAX_YEAR > YEAR_FIELD_MAX) ? YEAR_FIELD_MAX : MAX_YEAR;

	localparam int ACC_W = 24;  // day accumulator
	localparam int YR_W  = 15;  // working year, may run past the limit
	localparam int CYC_W = 9;   // year position inside the 400-year cycle

	localparam logic [13:0]      YEAR_LIMIT  = 14'(YEAR_LIMIT_INT);
	localparam logic [ACC_W-1:0] CYCLE_DAYS  = ACC_W'(146097);
	localparam logic [ACC_W-1:0] CYCLE_YEARS = ACC_W'(400);
	localparam logic [21:0]      DIFF_MAX    = 22'h3FFFFF;
	localparam logic [CYC_W-1:0] CYC_LAST    = CYC_W'(399);

	localparam logic [4:0] MONTH_LEN [13] = '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31,
		5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

	localparam logic OP_DIFF = 1'b0;
	localparam logic OP_ADD  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_LATER    = 2'd2,
		ST_OVERFLOW = 2'd3
	} cda_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MOD_B,
		S_MOD_A,
		S_CHECK,
		S_DY_BIG,
		S_DY_ONE,
		S_MON_A,
		S_MON_B,
		S_AY_BIG,
		S_AY_ONE,
		S_AMON
	} cda_state_t;

	typedef struct packed {
		logic        operation;
		logic [4:0]  day_a;
		logic [3:0]  month_a;
		logic [13:0] year_a;
		logic [4:0]  day_b;
		logic [3:0]  month_b;
		logic [13:0] year_b;
		logic [19:0] add_count;
	} cda_req_t;

	typedef struct packed {
		logic [21:0] day_difference;
		logic [4:0]  day_out;
		logic [3:0]  month_out;
		logic [13:0] year_out;
		cda_status_t status;
	} cda_rsp_t;

	typedef struct packed {
		logic [ACC_W-1:0] a;
		logic [ACC_W-1:0] b;
		logic             sub;
	} cda_alu_op_t;

	typedef struct packed {
		logic [ACC_W-1:0] res;
		logic             borrow;
	} cda_alu_res_t;

	function automatic logic is_leap(input logic [CYC_W-1:0] c);
		return (c[1:0] == 2'd0) &&
			!(c == CYC_W'(100) || c == CYC_W'(200) || c == CYC_W'(300));
	endfunction

	function automatic logic [8:0] days_in_year(input logic [CYC_W-1:0] c);
		return is_leap(c) ? 9'd366 : 9'd365;
	endfunction

	function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		if (m == 4'd2 && leap)
			d = 5'd29;
		else if (m >= 4'd1 && m <= 4'd12)
			d = MONTH_LEN[m];
		else
			d = 5'd0;
		return d;
	endfunction

	function automatic logic date_valid(input logic [4:0] d, input logic [3:0] m,
		input logic [13:0] y, input logic leap);
		return (m >= 4'd1) && (m <= 4'd12) && (d >= 5'd1) && (y <= YEAR_LIMIT) &&
			(d <= month_length(m, leap));
	endfunction

	function automatic logic [CYC_W-1:0] cyc_next(input logic [CYC_W-1:0] c);
		return (c == CYC_LAST) ? '0 : c + CYC_W'(1);
	endfunction

endpackage

@@ rtl/calendar_date_arithmetic.sv @@
// Top level of the calendar date arithmetic block: sequencer, shared
// add/subtract unit and the result register. Depends on cda_pkg, cda_alu, cda_seq.
//
// Gregorian date arithmetic on one request item at a time. Raise start with a
// request while busy is low; the item is taken at that edge and busy stays high
// until the answer is ready. The answer appears on result, with done high for exactly
// one cycle, and busy drops in that same cycle, so a new item may be started
// right away. There is no backpressure on the result side: capture it when done
// is high. Difference mode (operation 0) returns the days from the second date to
// the first; add mode (operation 1) advances the first date by add_count days and
// saturates to 31 December of the year limit with status 3 past it. An invalid
// date gives status 1 with all other fields zero; a second date later than the
// first gives status 2. Every cycle runs one step on a single add/subtract unit:
// each year field is first reduced modulo 400 by repeated subtraction of 400,
// then whole 400-year cycles, single years and months are stepped.
module calendar_date_arithmetic import cda_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  cda_req_t request,
	output logic     done,
	output cda_rsp_t result
);

	cda_alu_op_t  alu_op;
	cda_alu_res_t alu_res;
	logic         seq_done;
	cda_rsp_t     seq_rsp;
	logic         done_q;
	cda_rsp_t     result_q;

	cda_alu u_alu (
		.op  (alu_op),
		.res (alu_res)
	);

	cda_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (seq_done),
		.rsp     (seq_rsp),
		.alu_op  (alu_op),
		.alu_res (alu_res)
	);

	// Hold the strobe for one cycle only; the answer itself needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= seq_done;
		end
	end

	// Capture the finished item; keep the last one between strobes.
	always_ff @(posedge clk) begin
		if (seq_done) begin
			result_q <= seq_rsp;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ rtl/cda_alu.sv @@
// Shared add/subtract unit of the date sequencer; the borrow doubles as the
// greater-or-equal compare. Depends on cda_pkg.
module cda_alu import cda_pkg::*; (
	input  cda_alu_op_t  op,
	output cda_alu_res_t res
);

	logic [ACC_W:0] sum;

	always_comb begin
		if (op.sub)
			sum = {1'b0, op.a} - {1'b0, op.b};
		else
			sum = {1'b0, op.a} + {1'b0, op.b};
		res.res    = sum[ACC_W-1:0];
		res.borrow = op.sub & sum[ACC_W];
	end

endmodule

@@ rtl/cda_seq.sv @@
// Sequencer for calendar date arithmetic: walks years, 400-year cycles and
// months through the shared add/subtract unit. Depends on cda_pkg.
module cda_seq import cda_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  cda_req_t     request,
	output logic         busy,
	output logic         done,
	output cda_rsp_t     rsp,
	output cda_alu_op_t  alu_op,
	input  cda_alu_res_t alu_res
);

	cda_state_t       state_q, state_d;
	cda_req_t         req_q, req_d;
	logic [13:0]      red_q, red_d;
	logic [CYC_W-1:0] cyc_a_q, cyc_a_d, cyc_b_q, cyc_b_d, cyc_q, cyc_d;
	logic [ACC_W-1:0] acc_q, acc_d;
	logic [YR_W-1:0]  yr_q, yr_d;
	logic [3:0]       mon_q, mon_d;

	logic valid_a, valid_b, b_later;

	assign busy = (state_q != S_IDLE);

	assign valid_a = date_valid(req_q.day_a, req_q.month_a, req_q.year_a, is_leap(cyc_a_q));
	assign valid_b = date_valid(req_q.day_b, req_q.month_b, req_q.year_b, is_leap(cyc_b_q));
	assign b_later = (req_q.year_b > req_q.year_a) ||
		(req_q.year_b == req_q.year_a && req_q.month_b > req_q.month_a) ||
		(req_q.year_b == req_q.year_a && req_q.month_b == req_q.month_a &&
		 req_q.day_b > req_q.day_a);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q   <= req_d;
		red_q   <= red_d;
		cyc_a_q <= cyc_a_d;
		cyc_b_q <= cyc_b_d;
		cyc_q   <= cyc_d;
		acc_q   <= acc_d;
		yr_q    <= yr_d;
		mon_q   <= mon_d;
	end

	always_comb begin
		state_d = state_q;
		req_d   = req_q;
		red_d   = red_q;
		cyc_a_d = cyc_a_q;
		cyc_b_d = cyc_b_q;
		cyc_d   = cyc_q;
		acc_d   = acc_q;
		yr_d    = yr_q;
		mon_d   = mon_q;
		alu_op  = '{a: acc_q, b: '0, sub: 1'b0};
		done    = 1'b0;
		rsp     = '{day_difference: '0, day_out: '0, month_out: '0, year_out: '0,
			status: ST_OK};

		case (state_q)
			S_IDLE: begin
				if (start) begin
					req_d   = request;
					red_d   = request.year_b;
					state_d = S_MOD_B;
				end
			end
			// reduce each year modulo 400 by repeated subtraction
			S_MOD_B: begin
				alu_op = '{a: ACC_W'(red_q), b: CYCLE_YEARS, sub: 1'b1};
				if (!alu_res.borrow) begin
					red_d = alu_res.res[13:0];
				end else begin
					cyc_b_d = red_q[CYC_W-1:0];
					red_d   = req_q.year_a;
					state_d = S_MOD_A;
				end
			end
			S_MOD_A: begin
				alu_op = '{a: ACC_W'(red_q), b: CYCLE_YEARS, sub: 1'b1};
				if (!alu_res.borrow) begin
					red_d = alu_res.res[13:0];
				end else begin
					cyc_a_d = red_q[CYC_W-1:0];
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (req_q.operation == OP_DIFF) begin
					if (!valid_a || !valid_b) begin
						done       = 1'b1;
						rsp.status = ST_INVALID;
						state_d    = S_IDLE;
					end else if (b_later) begin
						done       = 1'b1;
						rsp.status = ST_LATER;
						state_d    = S_IDLE;
					end else begin
						acc_d   = '0;
						yr_d    = YR_W'(req_q.year_b);
						cyc_d   = cyc_b_q;
						state_d = S_DY_BIG;
					end
				end else begin
					if (!valid_a) begin
						done       = 1'b1;
						rsp.status = ST_INVALID;
						state_d    = S_IDLE;
					end else begin
						alu_op  = '{a: ACC_W'(req_q.add_count),
							b: ACC_W'(req_q.day_a - 5'd1), sub: 1'b0};
						acc_d   = alu_res.res;
						mon_d   = 4'd1;
						state_d = S_MON_A;
					end
				end
			end
			S_DY_BIG: begin
				if (yr_q + YR_W'(400) <= YR_W'(req_q.year_a)) begin
					alu_op = '{a: acc_q, b: CYCLE_DAYS, sub: 1'b0};
					acc_d  = alu_res.res;
					yr_d   = yr_q + YR_W'(400);
				end else begin
					state_d = S_DY_ONE;
				end
			end
			S_DY_ONE: begin
				if (yr_q < YR_W'(req_q.year_a)) begin
					alu_op = '{a: acc_q, b: ACC_W'(days_in_year(cyc_q)), sub: 1'b0};
					acc_d  = alu_res.res;
					yr_d   = yr_q + YR_W'(1);
					cyc_d  = cyc_next(cyc_q);
				end else begin
					alu_op  = '{a: acc_q, b: ACC_W'(req_q.day_a), sub: 1'b0};
					acc_d   = alu_res.res;
					mon_d   = 4'd1;
					state_d = S_MON_A;
				end
			end
			S_MON_A: begin
				if (mon_q < req_q.month_a) begin
					alu_op = '{a: acc_q,
						b: ACC_W'(month_length(mon_q, is_leap(cyc_a_q))), sub: 1'b0};
					acc_d  = alu_res.res;
					mon_d  = mon_q + 4'd1;
				end else if (req_q.operation == OP_DIFF) begin
					alu_op  = '{a: acc_q, b: ACC_W'(req_q.day_b), sub: 1'b1};
					acc_d   = alu_res.res;
					mon_d   = 4'd1;
					state_d = S_MON_B;
				end else begin
					yr_d    = YR_W'(req_q.year_a);
					cyc_d   = cyc_a_q;
					state_d = S_AY_BIG;
				end
			end
			S_MON_B: begin
				if (mon_q < req_q.month_b) begin
					alu_op = '{a: acc_q,
						b: ACC_W'(month_length(mon_q, is_leap(cyc_b_q))), sub: 1'b1};
					acc_d  = alu_res.res;
					mon_d  = mon_q + 4'd1;
				end else begin
					done    = 1'b1;
					state_d = S_IDLE;
					if (acc_q > ACC_W'(DIFF_MAX)) begin
						rsp.day_difference = DIFF_MAX;
						rsp.status         = ST_OVERFLOW;
					end else begin
						rsp.day_difference = acc_q[21:0];
					end
				end
			end
			S_AY_BIG: begin
				alu_op = '{a: acc_q, b: CYCLE_DAYS, sub: 1'b1};
				if (!alu_res.borrow) begin
					acc_d = alu_res.res;
					yr_d  = yr_q + YR_W'(400);
				end else begin
					state_d = S_AY_ONE;
				end
			end
			S_AY_ONE: begin
				alu_op = '{a: acc_q, b: ACC_W'(days_in_year(cyc_q)), sub: 1'b1};
				if (yr_q > YR_W'(YEAR_LIMIT)) begin
					done          = 1'b1;
					rsp.day_out   = 5'd31;
					rsp.month_out = 4'd12;
					rsp.year_out  = YEAR_LIMIT;
					rsp.status    = ST_OVERFLOW;
					state_d       = S_IDLE;
				end else if (!alu_res.borrow) begin
					acc_d = alu_res.res;
					yr_d  = yr_q + YR_W'(1);
					cyc_d = cyc_next(cyc_q);
				end else begin
					mon_d   = 4'd1;
					state_d = S_AMON;
				end
			end
			S_AMON: begin
				alu_op = '{a: acc_q,
					b: ACC_W'(month_length(mon_q, is_leap(cyc_q))), sub: 1'b1};
				if (mon_q < 4'd12 && !alu_res.borrow) begin
					acc_d = alu_res.res;
					mon_d = mon_q + 4'd1;
				end else begin
					done          = 1'b1;
					rsp.day_out   = acc_q[4:0] + 5'd1;
					rsp.month_out = mon_q;
					rsp.year_out  = yr_q[13:0];
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/cda_checker.sv @@
// Port-level checks of the calendar date arithmetic block, bound to its top
// level. Depends on cda_pkg and calendar_date_arithmetic.
module cda_checker import cda_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     done,
	input cda_rsp_t result
);

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after an accepted item");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_busy_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_INVALID) |->
		(result.day_difference == '0 && result.day_out == '0 &&
		 result.month_out == '0 && result.year_out == '0))
		else $error("invalid date with nonzero result fields");

	a_modes_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.day_difference != '0) |-> (result.month_out == '0))
		else $error("difference and date fields both set");

endmodule

bind calendar_date_arithmetic cda_checker u_cda_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.result  (result)
);

@@ bench/tb_calendar_date_arithmetic.sv @@
// Self-checking testbench for calendar_date_arithmetic: directed and random date requests,
// with a built-in Gregorian calendar predictor checking every result.
// Depends on cda_pkg and the calendar_date_arithmetic RTL.
module tb_calendar_date_arithmetic;
	import cda_pkg::*;

	localparam int RANDOM_ITEMS = 115;
	localparam int TAIL_ITEMS   = 25;    // no sender gaps once this few items remain
	localparam int DRAIN_CYCLES = 600;
	localparam int STALL_LIMIT  = 4000;  // cycles without any handshake before giving up
	localparam int REPORT_MAX   = 10;
	localparam longint unsigned DAYS_PER_400Y = 146097;

	typedef struct packed {
		logic [4:0]  d;
		logic [3:0]  m;
		logic [13:0] y;
	} date_t;

	logic     clk;
	logic     arst_n;
	logic     start = 1'b0;
	logic     busy;
	cda_req_t request = '0;
	logic     done;
	cda_rsp_t result;

	cda_req_t pending_requests [$];
	cda_rsp_t predicted_results [$];
	logic     item_taken = 1'b0;
	int       gap_left = 0;
	int       fail_count = 0;
	int       stall_cycles = 0;

	calendar_date_arithmetic DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------- calendar predictor

	function automatic logic leap_year(longint unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned month_days(int unsigned m, longint unsigned y);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return leap_year(y) ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	function automatic logic date_ok(int unsigned d, int unsigned m, int unsigned y);
		return m >= 1 && m <= 12 && d >= 1 && y <= YEAR_LIMIT && d <= month_days(m, y);
	endfunction

	// Days in all years before year y, counting from year 0 (a leap year).
	function automatic longint unsigned days_before(longint unsigned y);
		return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
	endfunction

	function automatic longint unsigned ordinal_day(int unsigned d, int unsigned m,
		int unsigned y);
		longint unsigned n;
		n = d;
		for (int unsigned i = 1; i < m && i <= 12; i++)
			n += month_days(i, y);
		return n;
	endfunction

	function automatic cda_rsp_t calendar_result(cda_req_t q);
		cda_rsp_t        r;
		longint unsigned span;
		longint unsigned total;
		longint unsigned yr;
		longint unsigned rem;
		int unsigned     mon;
		r = '0;
		r.status = ST_OK;
		if (q.operation == OP_DIFF) begin
			if (!date_ok(q.day_a, q.month_a, q.year_a)
				|| !date_ok(q.day_b, q.month_b, q.year_b)) begin
				r.status = ST_INVALID;
			end else if ({q.year_b, q.month_b, q.day_b} > {q.year_a, q.month_a, q.day_a}) begin
				r.status = ST_LATER;
			end else begin
				span = days_before(q.year_a) - days_before(q.year_b)
					+ ordinal_day(q.day_a, q.month_a, q.year_a)
					- ordinal_day(q.day_b, q.month_b, q.year_b);
				if (span > DIFF_MAX) begin
					r.day_difference = DIFF_MAX;
					r.status = ST_OVERFLOW;
				end else begin
					r.day_difference = span[21:0];
				end
			end
		end else if (!date_ok(q.day_a, q.month_a, q.year_a)) begin
			r.status = ST_INVALID;
		end else begin
			// Day number from 1 Jan of year 0, then peel 400-year blocks, years, months.
			total = days_before(q.year_a) + ordinal_day(q.day_a, q.month_a, q.year_a) - 1
				+ q.add_count;
			yr  = (total / DAYS_PER_400Y) * 400;
			rem = total % DAYS_PER_400Y;
			while (rem >= (leap_year(yr % 400) ? 366 : 365)) begin
				rem -= leap_year(yr % 400) ? 366 : 365;
				yr++;
			end
			if (yr > YEAR_LIMIT) begin
				r.day_out   = 5'd31;
				r.month_out = 4'd12;
				r.year_out  = YEAR_LIMIT;
				r.status    = ST_OVERFLOW;
			end else begin
				mon = 1;
				while (mon < 12 && rem >= month_days(mon, yr)) begin
					rem -= month_days(mon, yr);
					mon++;
				end
				r.day_out   = 5'(rem + 1);
				r.month_out = 4'(mon);
				r.year_out  = 14'(yr);
			end
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic cda_req_t make_req(logic op, date_t a, date_t b, logic [19:0] cnt);
		cda_req_t q;
		q.operation = op;
		q.day_a     = a.d;
		q.month_a   = a.m;
		q.year_a    = a.y;
		q.day_b     = b.d;
		q.month_b   = b.m;
		q.year_b    = b.y;
		q.add_count = cnt;
		return q;
	endfunction

	function automatic date_t dt(int d, int m, int y);
		return '{d: 5'(d), m: 4'(m), y: 14'(y)};
	endfunction

	// Valid date in the given year, any month.
	function automatic date_t date_in_year(int unsigned y);
		date_t v;
		v.y = 14'(y);
		v.m = 4'($urandom_range(1, 12));
		v.d = 5'($urandom_range(1, month_days(v.m, y)));
		return v;
	endfunction

	// Years biased toward century edges, small years and the top of the range.
	function automatic int unsigned pick_year();
		case ($urandom_range(0, 5))
			0:       return $urandom_range(0, 99);
			1:       return $urandom_range(0, YEAR_LIMIT);
			2:       return $urandom_range(9000, YEAR_LIMIT);
			3:       return $urandom_range(0, 99) * 100;
			4:       return $urandom_range(1582, 2100);
			default: return $urandom_range(YEAR_LIMIT - 9, YEAR_LIMIT);
		endcase
	endfunction

	function automatic logic [19:0] pick_count();
		case ($urandom_range(0, 3))
			0:       return 20'($urandom_range(0, 31));
			1:       return 20'($urandom_range(0, 400));
			2:       return 20'($urandom_range(0, 100000));
			default: return 20'($urandom);
		endcase
	endfunction

	function automatic cda_req_t random_req();
		date_t a;
		date_t b;
		date_t t;
		int    kind;
		kind = $urandom_range(0, 19);
		if (kind < 9) begin
			// Difference of two well-formed dates, mostly in the right order.
			a = date_in_year(pick_year());
			if ($urandom_range(0, 3) == 0)
				b = date_in_year(a.y);
			else
				b = date_in_year(pick_year());
			if ({b.y, b.m, b.d} > {a.y, a.m, a.d} && $urandom_range(0, 4) != 0) begin
				t = a;
				a = b;
				b = t;
			end
			return make_req(OP_DIFF, a, b, 20'($urandom));
		end else if (kind < 17) begin
			// Add days; the second date rides along as noise.
			a = date_in_year(pick_year());
			return make_req(OP_ADD, a, date_t'($urandom), pick_count());
		end else begin
			// Raw fields across their whole widths, mostly malformed.
			return cda_req_t'({$urandom, $urandom, $urandom});
		end
	endfunction

	// ---------------------------------------------------------------- driver

	// Present the next item on the falling edge; hold it until the block takes it.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || item_taken) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (pending_requests.size() == 0) begin
				start <= 1'b0;
			end else if (pending_requests.size() > TAIL_ITEMS
				&& $urandom_range(0, 5) == 0) begin
				// start an idle burst here; gap_left counts what remains of it
				gap_left <= $urandom_range(0, 13);
				start <= 1'b0;
			end else begin
				request <= pending_requests.pop_front();
				start <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	// Check the finished item first, then predict the one taken at this edge, so an
	// item started in the same cycle as the previous answer lands behind it.
	always @(posedge clk) begin
		cda_rsp_t want;
		item_taken <= arst_n && start && !busy;
		if (arst_n && done) begin
			if (predicted_results.size() == 0) begin
				fail_count <= fail_count + 1;
				if (fail_count < REPORT_MAX)
					$display("unexpected result: diff=%0d date=%0d-%0d-%0d status=%0d",
						result.day_difference, result.year_out, result.month_out,
						result.day_out, result.status);
			end else begin
				want = predicted_results.pop_front();
				if (result.day_difference !== want.day_difference
					|| result.day_out !== want.day_out
					|| result.month_out !== want.month_out
					|| result.year_out !== want.year_out
					|| result.status !== want.status) begin
					fail_count <= fail_count + 1;
					if (fail_count < REPORT_MAX)
						$display({"mismatch: expected diff=%0d date=%0d-%0d-%0d ",
							"status=%0d, got diff=%0d date=%0d-%0d-%0d status=%0d"},
							want.day_difference, want.year_out, want.month_out,
							want.day_out, want.status, result.day_difference,
							result.year_out, result.month_out, result.day_out,
							result.status);
				end
			end
		end
		if (arst_n && start && !busy)
			predicted_results.push_back(calendar_result(request));
	end

	// Abort if no item is taken and no result shows up for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n = 1'b0;

		// Directed: equal dates, leap and non-leap century Februaries, full range,
		// wrong order, each kind of malformed date, year 0 as a leap year.
		pending_requests.push_back(make_req(OP_DIFF, dt(15, 6, 2024), dt(15, 6, 2024), '0));
		pending_requests.push_back(make_req(OP_DIFF, dt(1, 3, 2000), dt(28, 2, 2000), '0));
		pending_requests.push_back(make_req(OP_DIFF, dt(1, 3, 1900), dt(28, 2, 1900), '1));
		pending_requests.push_back(make_req(OP_DIFF, dt(31, 12, 9999), dt(1, 1, 0), '0));
		pending_requests.push_back(make_req(OP_DIFF, dt(1, 1, 2001), dt(31, 12, 2000), '0));
		pending_requests.push_back(make_req(OP_DIFF, dt(1, 1, 2000), dt(2, 1, 2000), '0));
		pending_requests.push_back(make_req(OP_DIFF, dt(5, 5, 100), dt(5, 5, 200), '0));
		pending_requests.push_back(make_req(OP_DIFF, dt(0, 1, 2000), dt(1, 1, 1999), '0));
		pending_requests.push_back(make_req(OP_DIFF, dt(1, 1, 2000), dt(1, 13, 1999), '0));
		pending_requests.push_back(make_req(OP_DIFF, dt(31, 4, 2020), dt(1, 1, 2019), '0));
		pending_requests.push_back(make_req(OP_DIFF, dt(29, 2, 1900), dt(1, 1, 1800), '0));
		pending_requests.push_back(make_req(OP_DIFF, dt(1, 1, 10000), dt(1, 1, 1), '0));
		pending_requests.push_back(make_req(OP_DIFF, dt(31, 15, 16383), dt(31, 0, 16383), '1));
		pending_requests.push_back(make_req(OP_DIFF, dt(29, 2, 0), dt(1, 1, 0), '0));
		// Add mode: zero count, year and leap rollovers, largest count, saturation.
		pending_requests.push_back(make_req(OP_ADD, dt(15, 6, 2024), dt(0, 0, 0), '0));
		pending_requests.push_back(make_req(OP_ADD, dt(31, 12, 1999), dt(0, 0, 0), 20'd1));
		pending_requests.push_back(make_req(OP_ADD, dt(28, 2, 2000), dt(0, 0, 0), 20'd1));
		pending_requests.push_back(make_req(OP_ADD, dt(28, 2, 1900), dt(0, 0, 0), 20'd1));
		pending_requests.push_back(make_req(OP_ADD, dt(1, 1, 0), dt(0, 0, 0), '1));
		pending_requests.push_back(make_req(OP_ADD, dt(31, 12, 9999), dt(0, 0, 0), 20'd1));
		pending_requests.push_back(make_req(OP_ADD, dt(31, 12, 9999), dt(0, 0, 0), '0));
		pending_requests.push_back(make_req(OP_ADD, dt(29, 2, 2001), dt(0, 0, 0), 20'd5));
		pending_requests.push_back(make_req(OP_ADD, dt(1, 1, 10000), dt(0, 0, 0), 20'd5));
		pending_requests.push_back(make_req(OP_ADD, dt(1, 1, 9000), dt(31, 15, 16383), '1));
		pending_requests.push_back(make_req(OP_ADD, dt(29, 2, 2400), dt(0, 0, 0), 20'd365));

		for (int i = 0; i < RANDOM_ITEMS; i++)
			pending_requests.push_back(random_req());

		// Hold reset, then release it on a falling edge, away from the rising edge.
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Drain: everything sent, every answer back, then let the block settle.
		while (pending_requests.size() != 0 || start)
			@(posedge clk);
		while (predicted_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/cda_pkg.sv
rtl/cda_alu.sv
rtl/cda_seq.sv
rtl/calendar_date_arithmetic.sv
rtl/cda_checker.sv
bench/tb_calendar_date_arithmetic.sv
